### hdl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

`endif

### hdl/pse_pkg.sv
// types and constants of the pll setting checker and encoder
`timescale 1ns / 1ps

package pse_pkg;

    localparam int SRC_W  = 3;
    localparam int N_W    = 8;
    localparam int M_W    = 16;
    localparam int P_W    = 6;
    localparam int FREQ_W = 32;
    localparam int CCO_W  = 30;
    localparam int OUT_W  = 28;
    localparam int PROD_W = OUT_W + M_W;

    localparam logic [FREQ_W-1:0] IN_MIN_HZ   = 32'd2000;
    localparam logic [FREQ_W-1:0] IN_MAX_HZ   = 32'd150000000;
    localparam logic [PROD_W-1:0] CCO_MIN_HZ  = 44'd275000000;
    localparam logic [PROD_W-1:0] CCO_MAX_HZ  = 44'd550000000;
    localparam logic [CCO_W-1:0]  OUT_MIN_HZ  = 30'd4300000;
    localparam logic [CCO_W-1:0]  OUT_MAX_HZ  = 30'd150000000;
    localparam logic [M_W-1:0]    SELI_THR_HI = 16'd8000;
    localparam logic [M_W-1:0]    SELI_THR_LO = 16'd122;
    localparam logic [P_W-1:0]    P_MAX       = 6'd62;
    localparam logic [4:0]        SELP_CAP    = 5'd31;
    localparam logic [5:0]        SELI_CAP    = 6'd63;
    localparam logic [CCO_W-1:0]  SELI_DIVIDEND = 30'd8000;

    // default depths of the divider chains
    localparam int IN_DIV_BITS  = FREQ_W;
    localparam int OUT_DIV_BITS = CCO_W;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_BAD_M    = 4'd1,
        ST_BAD_N    = 4'd2,
        ST_BAD_P    = 4'd3,
        ST_BUSY     = 4'd4,
        ST_BAD_SRC  = 4'd5,
        ST_IN_UNDER = 4'd6,
        ST_IN_OVER  = 4'd7,
        ST_CCO_UNDER = 4'd8,
        ST_CCO_OVER = 4'd9,
        ST_OUT_UNDER = 4'd10,
        ST_OUT_OVER = 4'd11
    } status_t;

    typedef struct packed {
        status_t          status;
        logic [SRC_W-1:0] src;
        logic [N_W-1:0]   n;
        logic [M_W-1:0]   m;
        logic [P_W-1:0]   p;
    } req_t;

    localparam int REQ_W = $bits(req_t);

endpackage

### hdl/pll_setting_checker_encoder.sv
// pll request checker and register field encoder, top level
// a request passes the input divider chain, the product register, the output divider chain and the output register
// throughput: one request per cycle while the output is not stalled, set by the bit-per-cell divider chains
// the whole pipeline holds while a result waits on m_tready
// aresetn synchronous active low: clears all valid bits, payload is not reset
`timescale 1ns / 1ps

module pll_setting_checker_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pll_select[0], source_select[3:1], source_freq_hz[35:4], prediv_n[43:36],
    // mult_m[59:44], postdiv_p[65:60], pll_busy[66], zero[71:67]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[3:0], clock_sel[5:4], prediv_bypass[6], prediv_code[14:7],
    // mult_code[30:15], postdiv_bypass[31], postdiv_code[36:32], prop_gain[41:37],
    // int_gain[47:42], out_freq_hz[75:48], zero[79:76]
    output logic [79:0] m_tdata
);

    import pse_pkg::*;
    `include "assert_macros.svh"

    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // input decode and early checks
    logic [SRC_W-1:0]  in_src;
    logic [FREQ_W-1:0] in_freq;
    logic [N_W-1:0]    in_n;
    logic [M_W-1:0]    in_m;
    logic [P_W-1:0]    in_p;
    logic              in_busy;
    req_t              in_req;

    always_comb begin
        in_src  = s_tdata[3:1];
        in_freq = s_tdata[35:4];
        in_n    = s_tdata[43:36];
        in_m    = s_tdata[59:44];
        in_p    = s_tdata[65:60];
        in_busy = s_tdata[66];
        in_req.src = in_src;
        in_req.n   = in_n;
        in_req.m   = in_m;
        in_req.p   = in_p;
        if (in_m == '0) in_req.status = ST_BAD_M;
        else if (in_n == '0) in_req.status = ST_BAD_N;
        else if (in_p == '0 || in_p > P_MAX || (in_p > 6'd1 && in_p[0]))
            in_req.status = ST_BAD_P;
        else if (in_busy) in_req.status = ST_BUSY;
        else if (in_src > 3'd3) in_req.status = ST_BAD_SRC;
        else in_req.status = ST_OK;
    end

    // source divided by n
    logic              c1_valid;
    logic [FREQ_W-1:0] c1_q;
    logic [REQ_W-1:0]  c1_pay;

    pse_div_chain #(.DW(IN_DIV_BITS), .VW(N_W), .PW(REQ_W)) u_in_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (s_tvalid),
        .dividend (in_freq),
        .divisor  (in_n),
        .in_pay   (in_req),
        .out_valid(c1_valid),
        .quotient (c1_q),
        .out_pay  (c1_pay)
    );

    // input frequency check and oscillator product
    req_t              c1_req, mul_req_next;
    logic              mul_valid_reg;
    logic [PROD_W-1:0] mul_prod_reg;
    req_t              mul_req_reg;

    always_comb begin
        c1_req       = req_t'(c1_pay);
        mul_req_next = c1_req;
        if (c1_req.status == ST_OK) begin
            if (c1_q < IN_MIN_HZ) mul_req_next.status = ST_IN_UNDER;
            else if (c1_q > IN_MAX_HZ) mul_req_next.status = ST_IN_OVER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (adv) begin
            mul_valid_reg <= c1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mul_prod_reg <= PROD_W'(c1_q[OUT_W-1:0]) * PROD_W'(c1_req.m);
            mul_req_reg  <= mul_req_next;
        end
    end

    // oscillator check ahead of the output divider
    req_t cco_req;

    always_comb begin
        cco_req = mul_req_reg;
        if (mul_req_reg.status == ST_OK) begin
            if (mul_prod_reg < CCO_MIN_HZ) cco_req.status = ST_CCO_UNDER;
            else if (mul_prod_reg > CCO_MAX_HZ) cco_req.status = ST_CCO_OVER;
        end
    end

    logic             c2_valid;
    logic [CCO_W-1:0] c2_q;
    logic [REQ_W-1:0] c2_pay;

    pse_div_chain #(.DW(OUT_DIV_BITS), .VW(P_W), .PW(REQ_W)) u_out_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (mul_valid_reg),
        .dividend (mul_prod_reg[CCO_W-1:0]),
        .divisor  (mul_req_reg.p),
        .in_pay   (cco_req),
        .out_valid(c2_valid),
        .quotient (c2_q),
        .out_pay  (c2_pay)
    );

    // integral gain quotient runs alongside the output divider
    logic             c3_valid;
    logic [CCO_W-1:0] c3_q;
    logic             c3_hi;

    pse_div_chain #(.DW(OUT_DIV_BITS), .VW(M_W), .PW(1)) u_seli_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (mul_valid_reg),
        .dividend (SELI_DIVIDEND),
        .divisor  (mul_req_reg.m),
        .in_pay   (mul_req_reg.m >= SELI_THR_HI),
        .out_valid(c3_valid),
        .quotient (c3_q),
        .out_pay  (c3_hi)
    );

    // final checks and field encoding
    req_t        c2_req;
    status_t     fin_status;
    logic [4:0]  selp;
    logic [5:0]  seli;
    logic [75:0] res_next;
    logic        out_valid_reg;
    logic [75:0] res_reg;

    always_comb begin
        c2_req     = req_t'(c2_pay);
        fin_status = c2_req.status;
        if (c2_req.status == ST_OK) begin
            if (c2_q < OUT_MIN_HZ) fin_status = ST_OUT_UNDER;
            else if (c2_q > OUT_MAX_HZ) fin_status = ST_OUT_OVER;
        end
        selp = (c2_req.m[15:2] >= 14'd30) ? SELP_CAP : (c2_req.m[6:2] + 5'd1);
        if (c3_hi) seli = 6'd1;
        else if (c2_req.m >= SELI_THR_LO)
            seli = (c3_q > CCO_W'(SELI_CAP)) ? SELI_CAP : c3_q[5:0];
        else seli = {c2_req.m[6:2], 1'b0} + 6'd3;
        res_next = '0;
        res_next[3:0] = fin_status;
        if (fin_status == ST_OK) begin
            res_next[5:4]   = c2_req.src[1:0];
            res_next[6]     = (c2_req.n == 8'd1);
            res_next[14:7]  = (c2_req.n == 8'd1) ? '0 : c2_req.n;
            res_next[30:15] = c2_req.m;
            res_next[31]    = (c2_req.p == 6'd1);
            res_next[36:32] = (c2_req.p == 6'd1) ? '0 : c2_req.p[5:1];
            res_next[41:37] = selp;
            res_next[47:42] = seli;
            res_next[75:48] = c2_q[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= c2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, res_reg};

    `ASSERT_ALWAYS(a_chains_aligned, c2_valid == c3_valid, "divider chains out of step")
    `ASSERT_IMPLY(a_err_zero, m_tvalid && m_tdata[3:0] != ST_OK, m_tdata[79:4] == '0,
        "error result carries nonzero fields")
    `ASSERT_IMPLY(a_ok_range, m_tvalid && m_tdata[3:0] == ST_OK,
        m_tdata[75:48] >= OUT_MIN_HZ[OUT_W-1:0] && m_tdata[75:48] <= OUT_MAX_HZ[OUT_W-1:0],
        "ok result with output frequency out of range")

endmodule

### hdl/pse_div_cell.sv
// one restoring divider cell: produces one quotient bit and hands on
`timescale 1ns / 1ps

module pse_div_cell #(
    parameter int DW = 32,
    parameter int VW = 8,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [VW-1:0] in_rem,
    input  logic [DW-1:0] in_work,
    input  logic [VW-1:0] in_div,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [VW-1:0] out_rem,
    output logic [DW-1:0] out_work,
    output logic [VW-1:0] out_div,
    output logic [PW-1:0] out_pay
);

    logic          valid_reg;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] work_reg, work_next;
    logic [VW-1:0] div_reg;
    logic [PW-1:0] pay_reg;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    always_comb begin
        trial     = {in_rem, in_work[DW-1]};
        diff      = trial - {1'b0, in_div};
        ge        = trial >= {1'b0, in_div};
        rem_next  = ge ? diff[VW-1:0] : trial[VW-1:0];
        // dividend bits shift out the top, quotient bits shift in below
        work_next = {in_work[DW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
            div_reg  <= in_div;
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_work  = work_reg;
    assign out_div   = div_reg;
    assign out_pay   = pay_reg;

endmodule

### hdl/pse_div_chain.sv
// row of divider cells, one quotient bit per cell, msb first
`timescale 1ns / 1ps

module pse_div_chain #(
    parameter int DW = 32,
    parameter int VW = 8,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [DW-1:0] quotient,
    output logic [PW-1:0] out_pay
);

    logic          valid_w [0:DW];
    logic [VW-1:0] rem_w   [0:DW];
    logic [DW-1:0] work_w  [0:DW];
    logic [VW-1:0] div_w   [0:DW];
    logic [PW-1:0] pay_w   [0:DW];

    assign valid_w[0] = in_valid;
    assign rem_w[0]   = '0;
    assign work_w[0]  = dividend;
    assign div_w[0]   = divisor;
    assign pay_w[0]   = in_pay;

    for (genvar i = 0; i < DW; i++) begin : g_cell
        pse_div_cell #(.DW(DW), .VW(VW), .PW(PW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (valid_w[i]),
            .in_rem   (rem_w[i]),
            .in_work  (work_w[i]),
            .in_div   (div_w[i]),
            .in_pay   (pay_w[i]),
            .out_valid(valid_w[i+1]),
            .out_rem  (rem_w[i+1]),
            .out_work (work_w[i+1]),
            .out_div  (div_w[i+1]),
            .out_pay  (pay_w[i+1])
        );
    end

    assign out_valid = valid_w[DW];
    assign quotient  = work_w[DW];
    assign out_pay   = pay_w[DW];

endmodule
